>>> rtl/lct_pkg.sv
// Package with shared constants and types of the LRU cache hit tracker.
`default_nettype none

package lct_pkg;

  // Built size and field widths
  localparam int MaxEntries = 16;
  localparam int KeyWidth   = 32;
  localparam int CapWidth   = 5;
  localparam int RankWidth  = $clog2(MaxEntries);
  localparam int CntWidth   = $clog2(MaxEntries + 1);
  localparam int HitWidth   = 32;

  localparam logic [CapWidth-1:0] CapReset = CapWidth'(MaxEntries);

  typedef logic signed [KeyWidth-1:0] key_t;
  typedef logic [CapWidth-1:0]        cap_t;
  typedef logic [RankWidth-1:0]       rank_t;
  typedef logic [CntWidth-1:0]        cnt_t;
  typedef logic [HitWidth-1:0]        hit_cnt_t;
  typedef logic [MaxEntries-1:0]      entry_vec_t;

  // One result word
  typedef struct packed {
    logic     hit;
    logic     evicted_valid;
    key_t     evicted_key;
    hit_cnt_t hit_total;
  } res_t;

  // Handshake between the input register and the output register
  typedef struct packed {
    logic valid;
    logic ready;
  } push_t;

endpackage : lct_pkg

`default_nettype wire

>>> rtl/lct_if.sv
// Channel interfaces: key requests, lookup results and capacity writes.
`default_nettype none

interface lct_key_if
  import lct_pkg::*;
  ();
  logic valid;
  logic ready;
  key_t key;

  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface : lct_key_if

interface lct_res_if
  import lct_pkg::*;
  ();
  logic     valid;
  logic     ready;
  logic     hit;
  logic     evicted_valid;
  key_t     evicted_key;
  hit_cnt_t hit_total;

  modport source (output valid, output hit, output evicted_valid, output evicted_key,
                  output hit_total, input ready);
  modport sink (input valid, input hit, input evicted_valid, input evicted_key,
                input hit_total, output ready);
endinterface : lct_res_if

interface lct_cfg_if
  import lct_pkg::*;
  ();
  logic valid;
  logic ready;
  cap_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface : lct_cfg_if

`default_nettype wire

>>> rtl/lct_store.sv
// Entry store: parallel key compare, recency ranks, fill count and hit counter.
`default_nettype none

module lct_store
  import lct_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cap_we_i,
  input  wire cap_t cap_data_i,
  input  wire logic step_i,
  input  wire key_t key_i,
  output res_t      res_o
);

  key_t       keys_q [MaxEntries];
  rank_t      rank_q [MaxEntries];
  entry_vec_t valid_q;
  cnt_t       filled_q;
  hit_cnt_t   hits_q;
  cap_t       cap_q;

  entry_vec_t match_vec;
  entry_vec_t lru_vec;
  entry_vec_t free_vec;
  entry_vec_t wr_vec;
  logic       hit;
  logic       use_free;
  logic       evict;
  rank_t      match_rank;
  rank_t      lru_rank;
  cnt_t       filled_m1;
  cnt_t       eff_cap;
  key_t       ev_key;
  logic       seen_free;

  // Clamp the capacity register into 1..MaxEntries
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = cnt_t'(1);
    end else if (CntWidth'(cap_q) > cnt_t'(MaxEntries)) begin
      eff_cap = cnt_t'(MaxEntries);
    end else begin
      eff_cap = CntWidth'(cap_q);
    end
  end

  // Compare the key against every entry and pick the free and the least recent slots
  always_comb begin
    filled_m1  = filled_q - cnt_t'(1);
    lru_rank   = filled_m1[RankWidth-1:0];
    match_rank = '0;
    ev_key     = '0;
    seen_free  = 1'b0;
    for (int i = 0; i < MaxEntries; i++) begin
      match_vec[i] = valid_q[i] && (keys_q[i] == key_i);
      lru_vec[i]   = valid_q[i] && (rank_q[i] == lru_rank);
      free_vec[i]  = !valid_q[i] && !seen_free;
      seen_free    = seen_free || !valid_q[i];
      match_rank   = match_rank | (match_vec[i] ? rank_q[i] : '0);
    end
    hit      = |match_vec;
    use_free = !hit && (filled_q < eff_cap);
    evict    = !hit && !use_free;
    wr_vec   = hit ? '0 : (use_free ? free_vec : lru_vec);
    for (int i = 0; i < MaxEntries; i++) begin
      ev_key = ev_key | ((evict && lru_vec[i]) ? keys_q[i] : '0);
    end
  end

  // Form the result word
  always_comb begin
    res_o.hit           = hit;
    res_o.evicted_valid = evict;
    res_o.evicted_key   = ev_key;
    res_o.hit_total     = hits_q + HitWidth'(hit);
  end

  // Hold the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cap_we_i) begin
      cap_q <= cap_data_i;
    end
  end

  // Advance ranks, valid bits, fill count and hit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      filled_q <= '0;
      hits_q   <= '0;
      for (int i = 0; i < MaxEntries; i++) begin
        rank_q[i] <= '0;
      end
    end else if (step_i) begin
      hits_q <= hits_q + HitWidth'(hit);
      if (use_free) begin
        filled_q <= filled_q + cnt_t'(1);
      end
      for (int i = 0; i < MaxEntries; i++) begin
        if (match_vec[i] || wr_vec[i]) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && (!hit || (rank_q[i] < match_rank))) begin
          rank_q[i] <= rank_q[i] + rank_t'(1);
        end
        if (wr_vec[i]) begin
          valid_q[i] <= 1'b1;
        end
      end
    end
  end

  // Store the new key into the chosen slot
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int i = 0; i < MaxEntries; i++) begin
        if (wr_vec[i]) begin
          keys_q[i] <= key_i;
        end
      end
    end
  end

  a_fill_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(filled_q))
    else $error("fill count disagrees with valid bits");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("key stored in more than one entry");

  a_lru_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && evict) |-> $onehot(lru_vec))
    else $error("no unique least recent entry on eviction");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= cnt_t'(MaxEntries))
    else $error("fill count above built size");

endmodule : lct_store

`default_nettype wire

>>> rtl/lct_out_reg.sv
// Result register that drives the result channel.
`default_nettype none

module lct_out_reg
  import lct_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_valid_i,
  output push_t       push_o,
  input  wire res_t   res_i,
  lct_res_if.source   out_if
);

  logic vld_q;
  logic vld_d;
  res_t res_q;
  logic load;

  // Take a new word when empty or when the held word leaves
  assign push_o.ready = !vld_q || out_if.ready;
  assign push_o.valid = push_valid_i;
  assign load         = push_valid_i && push_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (out_if.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  // Drive the channel
  assign out_if.valid         = vld_q;
  assign out_if.hit           = res_q.hit;
  assign out_if.evicted_valid = res_q.evicted_valid;
  assign out_if.evicted_key   = res_q.evicted_key;
  assign out_if.hit_total     = res_q.hit_total;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !out_if.ready) |=> (vld_q && $stable(res_q)))
    else $error("result word changed while stalled");

  a_no_load_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !out_if.ready) |-> !load)
    else $error("result register overwritten");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> vld_q)
    else $error("loaded word not shown");

endmodule : lct_out_reg

`default_nettype wire

>>> rtl/lru_cache_hit_tracker_top.sv
// Top level of the LRU cache hit tracker: input register, entry store, result register.
//
// Usage:
//   in_if  carries one key word per handshake (valid and ready both high at a clock edge).
//   out_if returns one result word per key: hit, evicted_valid, evicted_key, hit_total.
//   cfg_if writes the capacity register (1..16 entries in use); it is always ready and
//   is to be written only while no key is in flight; the block does not enforce this.
// Result path: a key accepted into the input register passes through the entry store
//   into the result register once that register is free or its held word leaves.
// Throughput: one key per cycle while out_if takes result words; the key compare,
//   recency update and slot choice for a key all settle between the input and result
//   registers, so the next key in the input register sees the updated entries.
// Reset: all entries invalid, fill count and hit counter zero, capacity 16.
// Stall: when out_if.ready is low the result word holds; the input register takes a key
//   only while empty; in_if.ready then stays low until the result word leaves.
`default_nettype none

module lru_cache_hit_tracker_top
  import lct_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lct_key_if.sink   in_if,
  lct_res_if.source out_if,
  lct_cfg_if.sink   cfg_if
);

  logic  in_vld_q;
  logic  in_vld_d;
  key_t  key_q;
  logic  accept;
  logic  advance;
  push_t push;
  res_t  res;

  // Capacity writes are always taken
  assign cfg_if.ready = 1'b1;

  // Input register: refill when empty or when the held key moves on
  assign advance     = in_vld_q && push.ready;
  assign in_if.ready = !in_vld_q || advance;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= in_if.key;
    end
  end

  lct_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_we_i   (cfg_if.valid),
    .cap_data_i (cfg_if.data),
    .step_i     (advance),
    .key_i      (key_q),
    .res_o      (res)
  );

  lct_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_vld_q),
    .push_o       (push),
    .res_i        (res),
    .out_if       (out_if)
  );

  a_step_with_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> (in_vld_q && push.valid))
    else $error("store stepped without a key");

  a_key_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(key_q)))
    else $error("waiting key lost");

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_if.valid)
    else $error("stepped key produced no result word");

endmodule : lru_cache_hit_tracker_top

`default_nettype wire
